[hdl/skq_pkg.sv]
package skq_pkg;

	// Table geometry and fixed-point format.
	localparam int MAX_LM = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int FRAC_W = 4;
	localparam int EXTRA_W = 8;
	localparam int SHIFT_W = FRAC_W + EXTRA_W;

	// Datapath widths.
	localparam int XW = 16;
	localparam int YW = 17;
	localparam int AXW = 16;
	localparam int AYW = 17;
	localparam int D2W = 35;
	localparam int NW = 52;
	localparam int REM_W = 29;
	localparam int ROOT_W = 26;
	localparam int SQ_STEPS = 26;
	localparam int NUM_W = 23;
	localparam int DREM_W = 26;
	localparam int Q_W = 17;
	localparam int DV_STEPS = 17;
	localparam int CW = 27;
	localparam int PW = 13;
	localparam int RQ_W = CW + 1 - SHIFT_W;

	localparam logic signed [PW-1:0] PIX_MIN = -13'sd4096;
	localparam logic signed [PW-1:0] PIX_MAX = 13'sd4095;

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_LOAD  = 2'd1,
		OP_DRAW  = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_THICKNESS = 1'b0,
		CFG_OFFSET    = 1'b1
	} cfg_idx_t;

	// Segment data that travels along the pipeline.
	typedef struct packed {
		logic signed [XW-1:0] x1;
		logic signed [YW-1:0] y1;
		logic signed [XW-1:0] x2;
		logic signed [YW-1:0] y2;
		logic [AXW-1:0]       adx;
		logic [AYW-1:0]       ady;
		logic                 ndx;
		logic                 ndy;
		logic                 zero;
	} pay_t;

	// One stage of the square root pipeline.
	typedef struct packed {
		pay_t              pay;
		logic [NW-1:0]     n;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// One stage of the twin divider pipeline.
	typedef struct packed {
		pay_t              pay;
		logic [ROOT_W-1:0] len;
		logic [DREM_W-1:0] remx;
		logic [DREM_W-1:0] remy;
		logic [Q_W-1:0]    qx;
		logic [Q_W-1:0]    qy;
	} dv_t;

	// Round half away from zero to a whole pixel and saturate.
	function automatic logic [PW-1:0] to_pixel(input logic signed [CW-1:0] v);
		logic [CW-1:0]   mag;
		logic [CW:0]     sum;
		logic [RQ_W-1:0] q;
		logic [RQ_W-1:0] qn;
		mag = v[CW-1] ? CW'(-v) : CW'(v);
		sum = {1'b0, mag} + (CW+1)'(1 << (SHIFT_W - 1));
		q = sum[CW:SHIFT_W];
		qn = -q;
		if (v[CW-1]) begin
			to_pixel = (q > RQ_W'(4096)) ? PIX_MIN : qn[PW-1:0];
		end else begin
			to_pixel = (q > RQ_W'(4095)) ? PIX_MAX : q[PW-1:0];
		end
	endfunction

endpackage

[hdl/skq_ram.sv]
module skq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/skeleton_segment_to_quad_top.sv]
// A drawing connection word passes the table read, front, square root, divider, corner,
// pixel and output stages. Throughput: one input word per cycle while the skid word is empty;
// the 26-step square root and 17-step twin divider pipelines then each take a new segment.
// The landmark table is two copies of a 64-entry RAM, read at both indices at once.
// Reset: thickness 2; offset, flag, count, valid bits clear; table undefined until loaded.
module skeleton_segment_to_quad_top import skq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [11:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic                 detected,
	input  logic [CNT_W-1:0]     landmark_count,
	input  logic [IDX_W-1:0]     point_index,
	input  logic signed [15:0]   point_x,
	input  logic signed [15:0]   point_y,
	input  logic signed [7:0]    first_index,
	input  logic signed [7:0]    second_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [PW-1:0] corner_a_x,
	output logic signed [PW-1:0] corner_a_y,
	output logic signed [PW-1:0] corner_b_x,
	output logic signed [PW-1:0] corner_b_y,
	output logic signed [PW-1:0] corner_c_x,
	output logic signed [PW-1:0] corner_c_y,
	output logic signed [PW-1:0] corner_d_x,
	output logic signed [PW-1:0] corner_d_y
);

	logic [5:0]         thick_q;
	logic signed [11:0] offset_q;
	logic               det_q;
	logic [CNT_W-1:0]   count_q;
	logic               adv;
	logic               in_fire;
	logic               hit_c;
	logic [31:0]        rd_a;
	logic [31:0]        rd_b;
	logic [YW-1:0]      off_ext;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [XW-1:0]   x1_s2, x2_s2, x1_s3, x2_s3;
	logic signed [YW-1:0]   y1_s2, y2_s2, y1_s3, y2_s3;
	logic signed [XW:0]     dx_s3;
	logic signed [YW:0]     dy_s3;
	pay_t                   pay_s4, pay_s5;
	logic [2*AXW-1:0]       sqx_s5;
	logic [2*AYW-1:0]       sqy_s5;
	logic [D2W-1:0]         d2_c;

	sq_t  sq_s   [SQ_STEPS+1];
	sq_t  sq_nxt [SQ_STEPS];
	logic [SQ_STEPS:0] sqv_s;
	logic [REM_W-1:0] rem_sh [SQ_STEPS];
	logic [REM_W-1:0] trial  [SQ_STEPS];

	dv_t  dv_s   [DV_STEPS+1];
	dv_t  dv_nxt [DV_STEPS];
	logic [DV_STEPS:0] dvv_s;
	logic [DREM_W:0] tx [DV_STEPS];
	logic [DREM_W:0] ty [DV_STEPS];
	logic            gx [DV_STEPS];
	logic            gy [DV_STEPS];
	logic [NUM_W-1:0] numx_c;
	logic [NUM_W-1:0] numy_c;

	logic signed [CW-1:0] cr_c  [8];
	logic signed [CW-1:0] cr_s6 [8];
	logic [PW-1:0]        px_s7 [8];
	logic [PW-1:0]        out_q [8];
	logic [PW-1:0]        skid_q [8];
	logic                 skid_valid_q;
	logic                 out_valid_q;

	logic signed [CW-1:0] bx1, by1, bx2, by2, nx_c, ny_c, h_c;
	pay_t                 pl;

	// Handshake: the pipeline moves unless the skid word is occupied.
	assign adv = !skid_valid_q;
	assign in_ready = adv;
	assign in_fire = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= 6'd2;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THICKNESS: thick_q <= cfg_data[5:0];
				CFG_OFFSET:    offset_q <= cfg_data;
			endcase
		end
	end

	// Frame state: detected flag and saturated landmark count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= 1'b0;
			count_q <= '0;
		end else if (in_fire && op == OP_FRAME) begin
			det_q <= detected;
			count_q <= (landmark_count > CNT_W'(MAX_LM)) ? CNT_W'(MAX_LM) : landmark_count;
		end
	end

	// A connection draws only when detected and both indices are in range.
	assign hit_c = (op == OP_DRAW) && det_q && !first_index[7] && !second_index[7]
		&& (first_index[6:0] < count_q) && (second_index[6:0] < count_q);

	// Two copies of the landmark table give both endpoints in one read.
	skq_ram #(.WIDTH(32), .DEPTH(MAX_LM)) u_ram_a (
		.clk(clk),
		.we(in_fire && op == OP_LOAD),
		.waddr(point_index),
		.wdata({point_x, point_y}),
		.re(in_fire),
		.raddr(first_index[IDX_W-1:0]),
		.rdata(rd_a)
	);

	skq_ram #(.WIDTH(32), .DEPTH(MAX_LM)) u_ram_b (
		.clk(clk),
		.we(in_fire && op == OP_LOAD),
		.waddr(point_index),
		.wdata({point_x, point_y}),
		.re(in_fire),
		.raddr(second_index[IDX_W-1:0]),
		.rdata(rd_b)
	);

	assign off_ext = {offset_q[11], offset_q, {FRAC_W{1'b0}}};

	// Front stages: offset, differences, magnitudes, squares.
	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s2 <= rd_a[31:16];
			x2_s2 <= rd_b[31:16];
			y1_s2 <= {rd_a[15], rd_a[15:0]} + off_ext;
			y2_s2 <= {rd_b[15], rd_b[15:0]} + off_ext;

			x1_s3 <= x1_s2;
			x2_s3 <= x2_s2;
			y1_s3 <= y1_s2;
			y2_s3 <= y2_s2;
			dx_s3 <= {x2_s2[XW-1], x2_s2} - {x1_s2[XW-1], x1_s2};
			dy_s3 <= {y2_s2[YW-1], y2_s2} - {y1_s2[YW-1], y1_s2};

			pay_s4.x1 <= x1_s3;
			pay_s4.x2 <= x2_s3;
			pay_s4.y1 <= y1_s3;
			pay_s4.y2 <= y2_s3;
			pay_s4.adx <= dx_s3[XW] ? AXW'(-dx_s3) : AXW'(dx_s3);
			pay_s4.ady <= dy_s3[YW] ? AYW'(-dy_s3) : AYW'(dy_s3);
			pay_s4.ndx <= dx_s3[XW];
			pay_s4.ndy <= dy_s3[YW];
			pay_s4.zero <= (dx_s3 == '0) && (dy_s3 == '0);

			pay_s5 <= pay_s4;
			sqx_s5 <= pay_s4.adx * pay_s4.adx;
			sqy_s5 <= pay_s4.ady * pay_s4.ady;
		end
	end

	assign d2_c = D2W'(sqx_s5) + D2W'(sqy_s5);

	// Square root steps: one root bit per stage.
	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			rem_sh[k] = {sq_s[k].rem[REM_W-3:0], sq_s[k].n[NW-1:NW-2]};
			trial[k] = {1'b0, sq_s[k].root, 2'b01};
			sq_nxt[k].pay = sq_s[k].pay;
			sq_nxt[k].n = sq_s[k].n << 2;
			if (rem_sh[k] >= trial[k]) begin
				sq_nxt[k].rem = rem_sh[k] - trial[k];
				sq_nxt[k].root = {sq_s[k].root[ROOT_W-2:0], 1'b1};
			end else begin
				sq_nxt[k].rem = rem_sh[k];
				sq_nxt[k].root = {sq_s[k].root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].pay <= pay_s5;
			sq_s[0].n <= {1'b0, d2_c, 16'b0};
			sq_s[0].rem <= '0;
			sq_s[0].root <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_s[k+1] <= sq_nxt[k];
			end
		end
	end

	// Numerators of both normal components.
	assign numx_c = NUM_W'(sq_s[SQ_STEPS].pay.ady) * NUM_W'(thick_q);
	assign numy_c = NUM_W'(sq_s[SQ_STEPS].pay.adx) * NUM_W'(thick_q);

	// Divider steps: one quotient bit of each component per stage.
	always_comb begin
		for (int k = 0; k < DV_STEPS; k++) begin
			tx[k] = {dv_s[k].remx, 1'b0};
			ty[k] = {dv_s[k].remy, 1'b0};
			gx[k] = tx[k] >= {1'b0, dv_s[k].len};
			gy[k] = ty[k] >= {1'b0, dv_s[k].len};
			dv_nxt[k].pay = dv_s[k].pay;
			dv_nxt[k].len = dv_s[k].len;
			dv_nxt[k].remx = gx[k] ? DREM_W'(tx[k] - {1'b0, dv_s[k].len}) : DREM_W'(tx[k]);
			dv_nxt[k].remy = gy[k] ? DREM_W'(ty[k] - {1'b0, dv_s[k].len}) : DREM_W'(ty[k]);
			dv_nxt[k].qx = {dv_s[k].qx[Q_W-2:0], gx[k]};
			dv_nxt[k].qy = {dv_s[k].qy[Q_W-2:0], gy[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].pay <= sq_s[SQ_STEPS].pay;
			dv_s[0].len <= sq_s[SQ_STEPS].root;
			dv_s[0].remx <= DREM_W'({numx_c, 2'b00});
			dv_s[0].remy <= DREM_W'({numy_c, 2'b00});
			dv_s[0].qx <= '0;
			dv_s[0].qy <= '0;
			for (int k = 0; k < DV_STEPS; k++) begin
				dv_s[k+1] <= dv_nxt[k];
			end
		end
	end

	// Corner sums in pixel units with 12 fraction bits.
	always_comb begin
		pl = dv_s[DV_STEPS].pay;
		bx1 = {{(CW-XW-EXTRA_W){pl.x1[XW-1]}}, pl.x1, {EXTRA_W{1'b0}}};
		by1 = {{(CW-YW-EXTRA_W){pl.y1[YW-1]}}, pl.y1, {EXTRA_W{1'b0}}};
		bx2 = {{(CW-XW-EXTRA_W){pl.x2[XW-1]}}, pl.x2, {EXTRA_W{1'b0}}};
		by2 = {{(CW-YW-EXTRA_W){pl.y2[YW-1]}}, pl.y2, {EXTRA_W{1'b0}}};
		nx_c = pl.ndy ? CW'(dv_s[DV_STEPS].qx) : -CW'(dv_s[DV_STEPS].qx);
		ny_c = pl.ndx ? -CW'(dv_s[DV_STEPS].qy) : CW'(dv_s[DV_STEPS].qy);
		h_c = CW'({thick_q, {(SHIFT_W-1){1'b0}}});
		if (pl.zero) begin
			cr_c[0] = bx1 - h_c;
			cr_c[1] = by1 - h_c;
			cr_c[2] = bx1 - h_c;
			cr_c[3] = by1 + h_c;
			cr_c[4] = bx1 + h_c;
			cr_c[5] = by1 + h_c;
			cr_c[6] = bx1 + h_c;
			cr_c[7] = by1 - h_c;
		end else begin
			cr_c[0] = bx1 + nx_c;
			cr_c[1] = by1 + ny_c;
			cr_c[2] = bx2 + nx_c;
			cr_c[3] = by2 + ny_c;
			cr_c[4] = bx2 - nx_c;
			cr_c[5] = by2 - ny_c;
			cr_c[6] = bx1 - nx_c;
			cr_c[7] = by1 - ny_c;
		end
	end

	// Corner and pixel stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 8; i++) begin
				cr_s6[i] <= cr_c[i];
				px_s7[i] <= to_pixel(cr_s6[i]);
			end
		end
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sqv_s <= '0;
			dvv_s <= '0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && hit_c;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sqv_s <= {sqv_s[SQ_STEPS-1:0], v_s5};
			dvv_s <= {dvv_s[DV_STEPS-1:0], sqv_s[SQ_STEPS]};
			v_s6 <= dvv_s[DV_STEPS];
			v_s7 <= v_s6;
		end
	end

	// Output register with a skid word behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (v_s7) begin
			if (!out_valid_q || out_ready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (v_s7) begin
			if (!out_valid_q || out_ready) begin
				out_q <= px_s7;
			end else begin
				skid_q <= px_s7;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign corner_a_x = out_q[0];
	assign corner_a_y = out_q[1];
	assign corner_b_x = out_q[2];
	assign corner_b_y = out_q[3];
	assign corner_c_x = out_q[4];
	assign corner_c_y = out_q[5];
	assign corner_d_x = out_q[6];
	assign corner_d_y = out_q[7];

`ifndef SYNTHESIS
	// The skid word fills only behind a held output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word valid without output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid word filled while output drained");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LM))
		else $error("landmark count above table size");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dvv_s[DV_STEPS] && !dv_s[DV_STEPS].pay.zero) |->
		(dv_s[DV_STEPS].remx < dv_s[DV_STEPS].len && dv_s[DV_STEPS].remy < dv_s[DV_STEPS].len))
		else $error("divider remainder not below divisor");
`endif

endmodule

[test/tb.sv]
module tb;
	import skq_pkg::*;

	// Quad corners as one packed record, first end to fourth corner.
	typedef struct packed {
		logic signed [12:0] ax, ay, bx, by, cx, cy, dx, dy;
	} quad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [11:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = 2'd0;
	logic detected = 1'b0;
	logic [6:0] landmark_count = '0;
	logic [5:0] point_index = '0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic signed [7:0] first_index = '0;
	logic signed [7:0] second_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [12:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
	logic signed [12:0] corner_c_x, corner_c_y, corner_d_x, corner_d_y;

	skeleton_segment_to_quad_top uut (.*);

	// Predictor state.
	logic signed [15:0] lm_x [64];
	logic signed [15:0] lm_y [64];
	bit frame_detected;
	int unsigned frame_count;
	int unsigned thickness;
	longint y_shift;
	quad_t quads_due [$];

	int send_idle_pct;
	int stall_pct;
	int fail_count;
	longint cycle_count;

	initial begin
		forever #4 clk = ~clk;
	end

	// Global watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd1500000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [12:0] round_pixel(longint v);
		longint mag, q;
		mag = (v < 0) ? -v : v;
		q = (mag + 2048) >>> 12;
		if (v < 0) q = -q;
		if (q < -4096) q = -4096;
		if (q > 4095) q = 4095;
		return q[12:0];
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint normal_part(longint d, longint len);
		longint unsigned mag, q;
		mag = (d < 0) ? -d : d;
		q = ((mag * thickness) << 19) / len;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Quad for a connection between two loaded landmarks.
	function automatic quad_t segment_quad(int i1, int i2);
		longint x1, y1, x2, y2, ddx, ddy, nx, ny, h, len;
		quad_t q;
		x1 = lm_x[i1];
		x2 = lm_x[i2];
		y1 = lm_y[i1] + y_shift * 16;
		y2 = lm_y[i2] + y_shift * 16;
		ddx = x2 - x1;
		ddy = y2 - y1;
		x1 *= 256; y1 *= 256; x2 *= 256; y2 *= 256;
		if (ddx == 0 && ddy == 0) begin
			h = thickness * 2048;
			q = {round_pixel(x1 - h), round_pixel(y1 - h), round_pixel(x1 - h),
				round_pixel(y1 + h), round_pixel(x1 + h), round_pixel(y1 + h),
				round_pixel(x1 + h), round_pixel(y1 - h)};
		end else begin
			len = int_sqrt((ddx * ddx + ddy * ddy) << 16);
			nx = -normal_part(ddy, len);
			ny = normal_part(ddx, len);
			q = {round_pixel(x1 + nx), round_pixel(y1 + ny), round_pixel(x2 + nx),
				round_pixel(y2 + ny), round_pixel(x2 - nx), round_pixel(y2 - ny),
				round_pixel(x1 - nx), round_pixel(y1 - ny)};
		end
		return q;
	endfunction

	// Send one word and update the predictor when it is accepted.
	task automatic send_word(logic [1:0] o, logic det, logic [6:0] cnt, logic [5:0] slot,
			logic signed [15:0] px, logic signed [15:0] py,
			logic signed [7:0] i1, logic signed [7:0] i2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		detected <= det;
		landmark_count <= cnt;
		point_index <= slot;
		point_x <= px;
		point_y <= py;
		first_index <= i1;
		second_index <= i2;
		do @(posedge clk); while (!in_ready);
		case (o)
			OP_FRAME: begin
				frame_detected = det;
				frame_count = (cnt > 64) ? 64 : cnt;
			end
			OP_LOAD: begin
				lm_x[slot] = px;
				lm_y[slot] = py;
			end
			OP_DRAW: begin
				if (frame_detected && i1 >= 0 && i2 >= 0 && i1 < frame_count &&
						i2 < frame_count)
					quads_due = {quads_due, segment_quad(i1, i2)};
			end
			default: ;
		endcase
	endtask

	// Compare each accepted quad with the oldest prediction.
	always @(posedge clk) begin
		quad_t exp_q;
		if (out_valid && out_ready) begin
			if (quads_due.size() == 0) begin
				$error("quad with no prediction waiting");
				fail_count++;
			end else begin
				exp_q = quads_due.pop_front();
				if (corner_a_x !== exp_q.ax) begin
					$error("corner_a_x exp %0d got %0d", exp_q.ax, corner_a_x); fail_count++;
				end
				if (corner_a_y !== exp_q.ay) begin
					$error("corner_a_y exp %0d got %0d", exp_q.ay, corner_a_y); fail_count++;
				end
				if (corner_b_x !== exp_q.bx) begin
					$error("corner_b_x exp %0d got %0d", exp_q.bx, corner_b_x); fail_count++;
				end
				if (corner_b_y !== exp_q.by) begin
					$error("corner_b_y exp %0d got %0d", exp_q.by, corner_b_y); fail_count++;
				end
				if (corner_c_x !== exp_q.cx) begin
					$error("corner_c_x exp %0d got %0d", exp_q.cx, corner_c_x); fail_count++;
				end
				if (corner_c_y !== exp_q.cy) begin
					$error("corner_c_y exp %0d got %0d", exp_q.cy, corner_c_y); fail_count++;
				end
				if (corner_d_x !== exp_q.dx) begin
					$error("corner_d_x exp %0d got %0d", exp_q.dx, corner_d_x); fail_count++;
				end
				if (corner_d_y !== exp_q.dy) begin
					$error("corner_d_y exp %0d got %0d", exp_q.dy, corner_d_y); fail_count++;
				end
			end
		end
	end

	// Drop valid, drain outstanding quads, then let the pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (quads_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_THICKNESS) thickness = val[5:0];
		else y_shift = longint'($signed(val));
	endtask

	task automatic load_point(int slot, logic signed [15:0] px, logic signed [15:0] py);
		send_word(OP_LOAD, 1'b0, 7'd0, slot[5:0], px, py, 8'sd0, 8'sd0);
	endtask

	task automatic draw(logic signed [7:0] i1, logic signed [7:0] i2);
		send_word(OP_DRAW, 1'b0, 7'd0, 6'd0, 16'sd0, 16'sd0, i1, i2);
	endtask

	task automatic start_frame(logic det, logic [6:0] cnt);
		send_word(OP_FRAME, det, cnt, 6'd0, 16'sd0, 16'sd0, 8'sd0, 8'sd0);
	endtask

	// Field extremes, skip cases, equal ends and the unused op.
	task automatic test_directed();
		load_point(0, 16'sh7fff, 16'sh8000);
		load_point(1, 16'sh8000, 16'sh7fff);
		load_point(2, 16'sd100, 16'sd100);
		load_point(63, -16'sd1, 16'sd0);
		draw(8'sd0, 8'sd1);               // not detected yet
		start_frame(1'b1, 7'd127);        // count saturates
		draw(8'sd0, 8'sd1);
		draw(8'sd2, 8'sd2);               // equal ends give a square
		draw(8'sd63, 8'sd0);
		draw(-8'sd1, 8'sd0);              // negative index skips
		draw(8'sd0, 8'sd64);              // past the table
		draw(8'sd127, 8'sd0);
		send_word(2'd3, 1'b1, 7'd5, 6'd5, 16'sd5, 16'sd5, 8'sd1, 8'sd1);
		start_frame(1'b1, 7'd2);
		draw(8'sd1, 8'sd0);
		draw(8'sd0, 8'sd2);               // index not below count
		start_frame(1'b0, 7'd64);
		draw(8'sd0, 8'sd1);
		start_frame(1'b1, 7'd64);
		draw(8'sd2, 8'sd63);
		wait_drained();
	endtask

	// Mostly well-formed frames: loads, then draws among loaded points.
	task automatic test_random(int n_items, int idle, int stall);
		int sent, n_pts, k, i1, i2;
		send_idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			n_pts = $urandom_range(64, 2);
			for (k = 0; k < n_pts; k++) begin
				if ($urandom_range(3) == 0)
					load_point(k, 16'($urandom), 16'($urandom));
				else
					load_point(k, 16'($urandom_range(2000) - 1000),
						16'($urandom_range(2000) - 1000));
			end
			start_frame($urandom_range(9) != 0, ($urandom_range(9) == 0) ?
				7'($urandom_range(127)) : 7'(n_pts));
			sent += n_pts + 1;
			for (k = 0; k < 12; k++) begin
				i1 = $urandom_range(n_pts - 1);
				i2 = ($urandom_range(7) == 0) ? i1 : $urandom_range(n_pts - 1);
				if ($urandom_range(15) == 0) i1 = $urandom_range(255) - 128;
				if ($urandom_range(15) == 0) i2 = -1;
				if (i1 >= n_pts || i1 > 63) i1 = -1;
				draw(8'(i1), 8'(i2));
				sent++;
			end
			if ($urandom_range(7) == 0) begin
				send_word(2'd3, 1'($urandom), 7'($urandom), 6'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom), 8'($urandom));
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
		wait_drained();
	endtask

	initial begin
		send_idle_pct = 0;
		stall_pct = 0;
		fail_count = 0;
		frame_detected = 0;
		frame_count = 0;
		thickness = 2;
		y_shift = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_reg(CFG_THICKNESS, 12'd63);
		write_reg(CFG_OFFSET, 12'h800);
		test_random(450, 0, 0);
		write_reg(CFG_THICKNESS, 12'd0);
		write_reg(CFG_OFFSET, 12'h7ff);
		test_random(450, 84, 0);
		write_reg(CFG_THICKNESS, 12'd7);
		write_reg(CFG_OFFSET, 12'hff0);
		test_random(450, 0, 84);
		write_reg(CFG_THICKNESS, 12'($urandom_range(63)));
		write_reg(CFG_OFFSET, 12'($urandom_range(4095)));
		test_random(450, 31, 31);
		wait_drained();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

[files.f]
hdl/skq_pkg.sv
hdl/skq_ram.sv
hdl/skeleton_segment_to_quad_top.sv
test/tb.sv
